// File: design/sprite_local_to_world_transform_defines.svh
// Assertion macros used by the checker file.
`ifndef SPRITE_LOCAL_TO_WORLD_TRANSFORM_DEFINES_SVH
`define SPRITE_LOCAL_TO_WORLD_TRANSFORM_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SLWT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slwt check failed");

// Next-cycle implication, disabled while reset is held.
`define SLWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slwt check failed");

`endif

// File: design/slwt_pkg.sv
package slwt_pkg;

    // CORDIC: 17 micro-rotations, 30 fraction bits, angles in 2^-24 turn
    localparam int CORDIC_STEPS = 17;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int GEOM_LAT     = 4;
    localparam int GEOM_DLY     = CORDIC_LAT - GEOM_LAT;
    localparam int ROT_LAT      = 3;
    localparam int PIPE_LAT     = CORDIC_LAT + ROT_LAT;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [22:0] ATAN_TAB [CORDIC_STEPS] = '{
        23'd2097152, 23'd1238021, 23'd654136, 23'd332050, 23'd166669,
        23'd83416,   23'd41718,   23'd20860,  23'd10430,  23'd5215,
        23'd2608,    23'd1304,    23'd652,    23'd326,    23'd163,
        23'd81,      23'd41
    };

    localparam logic signed [23:0] WORLD_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] WORLD_MIN = 24'sh800000;

    // sine / cosine in Q1.14
    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] s;
    } t_trig;

    // offsets from the pivot and the pivot itself, 25 fraction bits
    typedef struct packed {
        logic               ok;
        logic signed [47:0] dx;
        logic signed [47:0] dy;
        logic signed [47:0] pvx;
        logic signed [47:0] pvy;
    } t_geom;

endpackage

// File: design/slwt_cordic.sv
module slwt_cordic
    import slwt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_rotation,
    output t_trig       o_trig
);

    logic signed [33:0] r_x [CORDIC_STEPS+1];
    logic signed [33:0] r_y [CORDIC_STEPS+1];
    logic signed [25:0] r_z [CORDIC_STEPS+1];
    logic [1:0]         r_q [CORDIC_STEPS+1];
    t_trig              r_trig;

    logic [16:0]        a_sum;
    logic [1:0]         a_q;
    logic [15:0]        a_res;

    // reduce to nearest quarter turn, residual in [-1/8, 1/8)
    always_comb begin
        a_sum = {1'b0, i_rotation} + 17'd8192;
        a_q   = a_sum[15:14];
        a_res = i_rotation - {a_q, 14'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_X0;
            r_y[0] <= '0;
            r_z[0] <= {{2{a_res[15]}}, a_res, 8'b0};
            r_q[0] <= a_q;
        end
    end

    // one micro-rotation per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        logic signed [25:0] at;
        always_comb begin
            xs = r_x[k] >>> k;
            ys = r_y[k] >>> k;
            at = signed'(26'(ATAN_TAB[k]));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[k][25]) begin
                    r_x[k+1] <= r_x[k] - ys;
                    r_y[k+1] <= r_y[k] + xs;
                    r_z[k+1] <= r_z[k] - at;
                end else begin
                    r_x[k+1] <= r_x[k] + ys;
                    r_y[k+1] <= r_y[k] - xs;
                    r_z[k+1] <= r_z[k] + at;
                end
                r_q[k+1] <= r_q[k];
            end
        end
    end

    logic signed [33:0] c_rnd;
    logic signed [33:0] s_rnd;
    logic signed [15:0] c_v;
    logic signed [15:0] s_v;

    // round to 14 fraction bits and unfold the quadrant
    always_comb begin
        c_rnd = (r_x[CORDIC_STEPS] + 34'sd32768) >>> 16;
        s_rnd = (r_y[CORDIC_STEPS] + 34'sd32768) >>> 16;
        c_v   = c_rnd[15:0];
        s_v   = s_rnd[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[CORDIC_STEPS])
                2'd0:    begin r_trig.c <= c_v;  r_trig.s <= s_v;  end
                2'd1:    begin r_trig.c <= -s_v; r_trig.s <= c_v;  end
                2'd2:    begin r_trig.c <= -c_v; r_trig.s <= -s_v; end
                default: begin r_trig.c <= s_v;  r_trig.s <= -c_v; end
            endcase
        end
    end

    assign o_trig = r_trig;

endmodule

// File: design/slwt_geom.sv
module slwt_geom
    import slwt_pkg::*;
#(
    parameter int SPRITE_W = 32,
    parameter int SPRITE_H = 32
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [7:0]         i_local_x,
    input  logic [7:0]         i_local_y,
    input  logic [1:0]         i_flip,
    input  logic               i_pivot_at_hotspot,
    input  logic [15:0]        i_scale,
    input  logic signed [15:0] i_skew_x,
    input  logic signed [15:0] i_skew_y,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [15:0] i_hot_x,
    input  logic signed [15:0] i_hot_y,
    output t_geom              o_geom
);

    logic [8:0]         fx;
    logic [8:0]         fy;

    // mirror by flip bits
    always_comb begin
        fx = i_flip[0] ? (9'(SPRITE_W - 1) - {1'b0, i_local_x}) : {1'b0, i_local_x};
        fy = i_flip[1] ? (9'(SPRITE_H - 1) - {1'b0, i_local_y}) : {1'b0, i_local_y};
    end

    // stage 1: range check, centred doubled coords, hotspot * scale
    logic               r1_ok, r1_hot;
    logic signed [9:0]  r1_ex, r1_ey;
    logic signed [32:0] r1_hsx, r1_hsy;
    logic [15:0]        r1_scale;
    logic signed [15:0] r1_kx, r1_ky;
    logic signed [23:0] r1_px, r1_py;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ok    <= ({1'b0, i_local_x} < 9'(SPRITE_W)) &&
                        ({1'b0, i_local_y} < 9'(SPRITE_H));
            r1_ex    <= signed'({fx, 1'b0} - 10'(SPRITE_W));
            r1_ey    <= signed'({fy, 1'b0} - 10'(SPRITE_H));
            r1_hsx   <= i_hot_x * signed'({1'b0, i_scale});
            r1_hsy   <= i_hot_y * signed'({1'b0, i_scale});
            r1_scale <= i_scale;
            r1_kx    <= i_skew_x;
            r1_ky    <= i_skew_y;
            r1_px    <= i_pos_x;
            r1_py    <= i_pos_y;
            r1_hot   <= i_pivot_at_hotspot;
        end
    end

    // stage 2: scaled offsets, centre offset from hotspot
    logic [24:0]        wsc, hsc;
    logic               r2_ok, r2_hot;
    logic signed [26:0] r2_lx, r2_ly;
    logic signed [38:0] r2_offx, r2_offy;
    logic signed [40:0] r2_pxs, r2_pys;
    logic signed [15:0] r2_kx, r2_ky;

    always_comb begin
        wsc = 25'(SPRITE_W) * 25'(r1_scale);
        hsc = 25'(SPRITE_H) * 25'(r1_scale);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ok   <= r1_ok;
            r2_hot  <= r1_hot;
            r2_lx   <= 27'(r1_ex * signed'({1'b0, r1_scale}));
            r2_ly   <= 27'(r1_ey * signed'({1'b0, r1_scale}));
            r2_offx <= signed'({2'b0, wsc, 12'b0}) - (39'(r1_hsx) <<< 5);
            r2_offy <= signed'({2'b0, hsc, 12'b0}) - (39'(r1_hsy) <<< 5);
            r2_pxs  <= {r1_px, 17'b0};
            r2_pys  <= {r1_py, 17'b0};
            r2_kx   <= r1_kx;
            r2_ky   <= r1_ky;
        end
    end

    // stage 3: shear products, pivot select
    logic               r3_ok;
    logic signed [26:0] r3_lx, r3_ly;
    logic signed [42:0] r3_kxly, r3_kylx;
    logic signed [38:0] r3_osx, r3_osy;
    logic signed [47:0] r3_pvx, r3_pvy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ok   <= r2_ok;
            r3_lx   <= r2_lx;
            r3_ly   <= r2_ly;
            r3_kxly <= r2_kx * r2_ly;
            r3_kylx <= r2_ky * r2_lx;
            r3_osx  <= r2_hot ? r2_offx : '0;
            r3_osy  <= r2_hot ? r2_offy : '0;
            r3_pvx  <= r2_hot ? 48'(r2_pxs) : (48'(r2_pxs) + 48'(r2_offx));
            r3_pvy  <= r2_hot ? 48'(r2_pys) : (48'(r2_pys) + 48'(r2_offy));
        end
    end

    // stage 4: offset of the sheared point from the pivot
    t_geom r4_geom;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_geom.ok  <= r3_ok;
            r4_geom.dx  <= (48'(r3_lx) <<< 12) + 48'(r3_kxly) + 48'(r3_osx);
            r4_geom.dy  <= (48'(r3_ly) <<< 12) + 48'(r3_kylx) + 48'(r3_osy);
            r4_geom.pvx <= r3_pvx;
            r4_geom.pvy <= r3_pvy;
        end
    end

    // delay line to line up with sin / cos
    t_geom r_dly [GEOM_DLY];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= r4_geom;
            for (int i = 1; i < GEOM_DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign o_geom = r_dly[GEOM_DLY-1];

endmodule

// File: design/slwt_rotate.sv
module slwt_rotate
    import slwt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  t_geom              i_geom,
    input  t_trig              i_trig,
    output logic signed [23:0] o_world_x,
    output logic signed [23:0] o_world_y,
    output logic               o_valid_res
);

    // stage 1: rotation products
    logic               r1_ok;
    logic signed [63:0] r1_cdx, r1_sdy, r1_sdx, r1_cdy;
    logic signed [47:0] r1_pvx, r1_pvy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ok  <= i_geom.ok;
            r1_cdx <= i_trig.c * i_geom.dx;
            r1_sdy <= i_trig.s * i_geom.dy;
            r1_sdx <= i_trig.s * i_geom.dx;
            r1_cdy <= i_trig.c * i_geom.dy;
            r1_pvx <= i_geom.pvx;
            r1_pvy <= i_geom.pvy;
        end
    end

    // stage 2: sum, round to 8 fraction bits
    logic signed [63:0] sum_x, sum_y;
    logic               r2_ok;
    logic signed [32:0] r2_rx, r2_ry;

    always_comb begin
        sum_x = (64'(r1_pvx) <<< 14) + r1_cdx - r1_sdy + 64'sd1073741824;
        sum_y = (64'(r1_pvy) <<< 14) + r1_sdx + r1_cdy + 64'sd1073741824;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ok <= r1_ok;
            r2_rx <= sum_x[63:31];
            r2_ry <= sum_y[63:31];
        end
    end

    // stage 3: saturate, blank pixels outside the bitmap
    logic signed [23:0] sat_x, sat_y;

    always_comb begin
        if (r2_rx > 33'(WORLD_MAX))      sat_x = WORLD_MAX;
        else if (r2_rx < 33'(WORLD_MIN)) sat_x = WORLD_MIN;
        else                             sat_x = r2_rx[23:0];
        if (r2_ry > 33'(WORLD_MAX))      sat_y = WORLD_MAX;
        else if (r2_ry < 33'(WORLD_MIN)) sat_y = WORLD_MIN;
        else                             sat_y = r2_ry[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_world_x   <= r2_ok ? sat_x : '0;
            o_world_y   <= r2_ok ? sat_y : '0;
            o_valid_res <= r2_ok;
        end
    end

endmodule

// File: design/sprite_local_to_world_transform.sv
// Channel | Handshake           | Beat payload
// in      | i_valid / o_ready   | local_x, local_y, flip, pivot, scale, skew, rotation, pos, hot
// out     | o_valid / i_ready   | world_x, world_y, valid_res
//
// One beat in per clock unless a waiting output beat stalls the pipe.
// Latency is set by the 17-stage CORDIC plus reduce, round and 3 rotate stages.
// Reset clears only the valid pipe; data registers are not reset.
// When the output holds an untaken beat, the whole pipe freezes and o_ready drops.
module sprite_local_to_world_transform
    import slwt_pkg::*;
#(
    parameter int SPRITE_W = 32,
    parameter int SPRITE_H = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_local_x,
    input  logic [7:0]         i_local_y,
    input  logic [1:0]         i_flip,
    input  logic               i_pivot_at_hotspot,
    input  logic [15:0]        i_scale,
    input  logic signed [15:0] i_skew_x,
    input  logic signed [15:0] i_skew_y,
    input  logic [15:0]        i_rotation,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [15:0] i_hot_x,
    input  logic signed [15:0] i_hot_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_world_x,
    output logic signed [23:0] o_world_y,
    output logic               o_valid_res
);

    logic          en;
    logic [PIPE_LAT-1:0] r_vld;
    t_geom         geom;
    t_trig         trig;

    // global advance: move unless the output beat is waiting
    assign en      = !r_vld[PIPE_LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[PIPE_LAT-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    slwt_geom #(
        .SPRITE_W (SPRITE_W),
        .SPRITE_H (SPRITE_H)
    ) u_geom (
        .i_clk              (i_clk),
        .i_en               (en),
        .i_local_x          (i_local_x),
        .i_local_y          (i_local_y),
        .i_flip             (i_flip),
        .i_pivot_at_hotspot (i_pivot_at_hotspot),
        .i_scale            (i_scale),
        .i_skew_x           (i_skew_x),
        .i_skew_y           (i_skew_y),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_hot_x            (i_hot_x),
        .i_hot_y            (i_hot_y),
        .o_geom             (geom)
    );

    slwt_cordic u_cordic (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_rotation (i_rotation),
        .o_trig     (trig)
    );

    slwt_rotate u_rotate (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_geom      (geom),
        .i_trig      (trig),
        .o_world_x   (o_world_x),
        .o_world_y   (o_world_y),
        .o_valid_res (o_valid_res)
    );

endmodule

// File: design/slwt_checker.sv
`include "sprite_local_to_world_transform_defines.svh"

module slwt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [23:0] o_world_x,
    input logic signed [23:0] o_world_y,
    input logic               o_valid_res
);

    // back-pressure only comes from a waiting output beat
    `SLWT_ASSERT_NOW(a_ready_only_on_stall, i_clk, i_rst_n, !o_ready, o_valid && !i_ready)

    // pixels outside the bitmap carry a zero position
    `SLWT_ASSERT_NOW(a_outside_zero, i_clk, i_rst_n, o_valid && !o_valid_res, (o_world_x == 24'sd0) && (o_world_y == 24'sd0))

    // a stalled beat stays put
    `SLWT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_world_x) && $stable(o_world_y) && $stable(o_valid_res))

    // after an output beat is taken, the pipe is either ready or holding a new output beat
    `SLWT_ASSERT_NEXT(a_ready_after_take, i_clk, i_rst_n, o_valid && i_ready, o_ready || o_valid)

endmodule

bind sprite_local_to_world_transform slwt_checker u_slwt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_world_x   (o_world_x),
    .o_world_y   (o_world_y),
    .o_valid_res (o_valid_res)
);

// File: sim/tb_sprite_local_to_world_transform.sv
module tb_sprite_local_to_world_transform;
    import slwt_pkg::*;

    localparam int SW = 32;
    localparam int SH = 32;
    localparam int N_RANDOM = 1130;

    typedef struct packed {
        logic [7:0]         lx;
        logic [7:0]         ly;
        logic [1:0]         flip;
        logic               hot_pivot;
        logic [15:0]        scale;
        logic signed [15:0] kx;
        logic signed [15:0] ky;
        logic [15:0]        rot;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] hx;
        logic signed [15:0] hy;
    } t_pixel;

    localparam int PIX_W = $bits(t_pixel);

    typedef struct packed {
        logic signed [23:0] wx;
        logic signed [23:0] wy;
        logic               in_bmp;
    } t_world;

    // directed row: pixel, plus a typed-in answer where it is obvious
    typedef struct {
        t_pixel pix;
        bit     known;
        t_world ans;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_ready = 1'b0;
    logic               o_valid;
    t_pixel             drv = '0;
    logic signed [23:0] o_world_x;
    logic signed [23:0] o_world_y;
    logic               o_valid_res;

    t_world world_q[$];
    int     n_bad = 0;
    int     phase = 0;
    bit     hold_off = 1'b0;

    always #5 i_clk = ~i_clk;

    sprite_local_to_world_transform #(.SPRITE_W(SW), .SPRITE_H(SH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_local_x(drv.lx), .i_local_y(drv.ly), .i_flip(drv.flip),
        .i_pivot_at_hotspot(drv.hot_pivot), .i_scale(drv.scale),
        .i_skew_x(drv.kx), .i_skew_y(drv.ky), .i_rotation(drv.rot),
        .i_pos_x(drv.px), .i_pos_y(drv.py), .i_hot_x(drv.hx), .i_hot_y(drv.hy),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_world_x(o_world_x), .o_world_y(o_world_y), .o_valid_res(o_valid_res)
    );

    function automatic longint fdiv(longint v, int n);
        return v >>> n;
    endfunction

    // angle to Q1.14 cosine/sine via quarter reduction and CORDIC
    function automatic void trig(input logic [15:0] rot, output longint c, output longint s);
        logic [1:0]  q;
        logic [15:0] res;
        longint x, y, z, xs, ys, cc, ss;
        q   = 2'((rot + 17'd8192) >> 14);
        res = rot - {q, 14'd0};
        z   = longint'($signed(res)) * 256;
        x   = 652032874;
        y   = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = fdiv(x, i);
            ys = fdiv(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
            end
        end
        cc = fdiv(x + 32768, 16);
        ss = fdiv(y + 32768, 16);
        case (q)
            2'd0: begin c = cc;  s = ss;  end
            2'd1: begin c = -ss; s = cc;  end
            2'd2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
        endcase
    endfunction

    function automatic logic signed [23:0] round_sat(longint v);
        longint r;
        r = fdiv(v + (longint'(1) << 30), 31);
        if (r > 8388607) return WORLD_MAX;
        if (r < -8388608) return WORLD_MIN;
        return 24'(r);
    endfunction

    function automatic t_world place_pixel(t_pixel p);
        t_world w;
        longint gx, gy, sc, lx, ly, sx, sy, cx, cy, pvx, pvy, dx, dy, c, s;
        w = '0;
        if (p.lx >= SW || p.ly >= SH) return w;
        gx = p.lx;
        gy = p.ly;
        if (p.flip[0]) gx = SW - 1 - gx;
        if (p.flip[1]) gy = SH - 1 - gy;
        sc = p.scale;
        lx = (2 * gx - SW) * sc;
        ly = (2 * gy - SH) * sc;
        sx = lx * 4096 + longint'(p.kx) * ly;
        sy = longint'(p.ky) * lx + ly * 4096;
        cx = longint'(p.px) * 131072 - longint'(p.hx) * sc * 32 + SW * sc * 4096;
        cy = longint'(p.py) * 131072 - longint'(p.hy) * sc * 32 + SH * sc * 4096;
        pvx = p.hot_pivot ? longint'(p.px) * 131072 : cx;
        pvy = p.hot_pivot ? longint'(p.py) * 131072 : cy;
        dx = cx + sx - pvx;
        dy = cy + sy - pvy;
        trig(p.rot, c, s);
        w.wx = round_sat(pvx * 16384 + (c * dx - s * dy));
        w.wy = round_sat(pvy * 16384 + (s * dx + c * dy));
        w.in_bmp = 1'b1;
        return w;
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel p;
        p = t_pixel'(PIX_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        // mostly in-bitmap pixels with modest geometry
        if ($urandom_range(0, 9) != 0) begin
            p.lx = 8'($urandom_range(0, SW - 1));
            p.ly = 8'($urandom_range(0, SH - 1));
        end
        if ($urandom_range(0, 3) != 0) begin
            p.scale = 16'($urandom_range(0, 16384));
            p.kx = 16'($signed($urandom_range(0, 8192)) - 4096);
            p.ky = 16'($signed($urandom_range(0, 8192)) - 4096);
            p.px = 24'($signed($urandom_range(0, 2000000)) - 1000000);
            p.py = 24'($signed($urandom_range(0, 2000000)) - 1000000);
        end
        return p;
    endfunction

    function automatic bit sender_idle();
        return (phase == 1 || phase == 3) && $urandom_range(0, 99) < (phase == 3 ? 19 : 71);
    endfunction

    // send one beat: valid held with the payload until accepted
    task automatic send_beat(t_pixel p);
        while (sender_idle()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        drv <= p;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        world_q.push_back(place_pixel(p));
        @(negedge i_clk);
    endtask

    // receiver side, sampled at the rising edge
    always @(posedge i_clk) begin
        t_world exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (world_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result beat x=%0d y=%0d", o_world_x, o_world_y);
            end else begin
                exp_w = world_q.pop_front();
                if (o_world_x !== exp_w.wx || o_world_y !== exp_w.wy
                        || o_valid_res !== exp_w.in_bmp) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("world exp (%0d,%0d,%0b) got (%0d,%0d,%0b)",
                                 exp_w.wx, exp_w.wy, exp_w.in_bmp,
                                 o_world_x, o_world_y, o_valid_res);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off) i_ready <= 1'b0;
        else if (phase == 2) i_ready <= $urandom_range(0, 99) >= 71;
        else if (phase == 3) i_ready <= $urandom_range(0, 99) >= 19;
        else i_ready <= 1'b1;
    end

    // long receiver stall while the sender keeps offering, to fill the pipe
    initial begin
        wait (phase == 1);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (3 * PIPE_LAT + 20) @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("sprite_local_to_world_transform: mismatch");
        $finish;
    end

    initial begin
        t_row   rows[$];
        t_row   r;
        t_pixel p;
        int     wait_cnt;
        // directed table
        p = '0; p.scale = 16'h1000;
        r.pix = p; r.known = 1'b0; r.ans = '0; rows.push_back(r);
        p.lx = 8'(SW); r.pix = p; r.known = 1'b1; r.ans = '0; rows.push_back(r);
        p.lx = 8'd0; p.ly = 8'(SH); r.pix = p; rows.push_back(r);
        p.lx = 8'hFF; p.ly = 8'hFF; r.pix = p; rows.push_back(r);
        // zero scale, no rotation: pixel sits on the hotspot
        p = '0; p.lx = 8'd5; p.ly = 8'd7; p.px = 24'sd1000; p.py = -24'sd2000;
        r.pix = p; r.known = 1'b1; r.ans = '{24'sd1000, -24'sd2000, 1'b1}; rows.push_back(r);
        r.known = 1'b0;
        for (int f = 0; f < 4; f++) begin
            p = '0; p.lx = 8'(SW - 1); p.ly = 8'd0; p.flip = 2'(f); p.scale = 16'hFFFF;
            p.hot_pivot = f[0]; p.rot = 16'(f * 16384 + 8191);
            p.kx = 16'sh7FFF; p.ky = 16'sh8000; p.hx = 16'sh8000; p.hy = 16'sh7FFF;
            r.pix = p; rows.push_back(r);
        end
        p = '0; p.lx = 8'(SW - 1); p.ly = 8'(SH - 1); p.scale = 16'hFFFF;
        p.px = WORLD_MAX; p.py = WORLD_MIN; p.rot = 16'hFFFF; p.hot_pivot = 1'b1;
        r.pix = p; rows.push_back(r);
        p.px = WORLD_MIN; p.py = WORLD_MAX; p.rot = 16'd8192; p.kx = 16'sh8000;
        r.pix = p; rows.push_back(r);
        p = '0; p.scale = 16'h1000; p.rot = 16'd16384; p.lx = 8'd3; p.ly = 8'd29;
        r.pix = p; rows.push_back(r);
        p.rot = 16'd32768; r.pix = p; rows.push_back(r);
        p.rot = 16'd49152; p.hx = 16'sh0800; p.hy = -16'sh0400; r.pix = p;
        rows.push_back(r);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            send_beat(rows[k].pix);
            if (rows[k].known && world_q[$] != rows[k].ans) begin
                n_bad++;
                if (n_bad <= 10) $display("directed row %0d predictor disagrees", k);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            phase = ph;
            for (int k = 0; k < N_RANDOM / 4; k++) send_beat(random_pixel());
        end
        i_valid <= 1'b0;
        phase = 0;

        wait_cnt = 0;
        while (world_q.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (n_bad == 0 && world_q.size() == 0)
            $display("sprite_local_to_world_transform: match");
        else
            $display("sprite_local_to_world_transform: mismatch");
        $finish;
    end

endmodule
